// ===== rtl/hcs_pkg.sv =====
package hcs_pkg;

    // Fixed field and state widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned STATUS_W = 8;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STEER_W  = 2;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned SUM_W    = 21;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    // Reciprocal divider precision: exact for any SUM_W-bit magnitude and divisor below 2**CNT_W
    localparam int unsigned DIV_SHIFT = SUM_W + CNT_W;
    localparam int unsigned RECIP_W   = DIV_SHIFT + 1;

    // Default window lengths
    localparam int unsigned CAL_SAMPLES_DEF = 10;
    localparam int unsigned AVG_SAMPLES_DEF = 5;

    // Register reset values and indexes
    localparam logic [CFG_W-1:0] MARGIN_RESET = 8'd8;
    localparam logic             DIR_RESET    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_DIR = 1'd1;

    // Sample is rejected when the status byte holds exactly this code
    localparam logic [STATUS_W-1:0] REJECT_STATUS = 8'h08;

    // Commands
    localparam logic [CMD_W-1:0] CMD_START_CAL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START_MEAS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd2;

    // Result codes
    localparam logic KIND_CAL   = 1'b0;
    localparam logic KIND_STEER = 1'b1;
    localparam logic [STEER_W-1:0] STEER_STRAIGHT = 2'd0;
    localparam logic [STEER_W-1:0] STEER_RIGHT    = 2'd1;
    localparam logic [STEER_W-1:0] STEER_LEFT     = 2'd2;

    // Travel direction rules
    localparam logic DIR_WEST_EAST = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic [STATUS_W-1:0]        status_byte;
        logic                       bus_error;
    } t_in_word;

    typedef struct packed {
        logic                       result_kind;
        logic [STEER_W-1:0]         steer;
        logic signed [SAMPLE_W-1:0] avg_x;
        logic signed [SAMPLE_W-1:0] avg_y;
        logic signed [SAMPLE_W-1:0] min_x;
        logic signed [SAMPLE_W-1:0] max_x;
        logic signed [SAMPLE_W-1:0] min_y;
        logic signed [SAMPLE_W-1:0] max_y;
    } t_out_word;

    typedef struct packed {
        logic [CFG_W-1:0] margin;
        logic             travel_direction;
    } t_cfg;

endpackage

// ===== rtl/hcs_avg_div.sv =====
module hcs_avg_div #(
    parameter int unsigned AVG_SAMPLES = hcs_pkg::AVG_SAMPLES_DEF
) (
    input  logic signed [hcs_pkg::SUM_W-1:0]    i_sum,
    output logic signed [hcs_pkg::SAMPLE_W-1:0] o_avg
);
    import hcs_pkg::*;

    localparam int unsigned PROD_W = SUM_W + RECIP_W;
    // ceil(2**DIV_SHIFT / AVG_SAMPLES)
    localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    logic                    neg;
    logic [SUM_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [SAMPLE_W-1:0]     quot;

    // Divide the magnitude by reciprocal multiply, then restore the sign (truncates toward zero)
    always_comb begin
        neg  = i_sum[SUM_W-1];
        mag  = neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        prod = PROD_W'(mag) * PROD_W'(AVG_RECIP);
        quot = prod[DIV_SHIFT +: SAMPLE_W];
        o_avg = neg ? SAMPLE_W'(-quot) : quot;
    end

endmodule

// ===== rtl/hcs_core.sv =====
module hcs_core #(
    parameter int unsigned CAL_SAMPLES = hcs_pkg::CAL_SAMPLES_DEF,
    parameter int unsigned AVG_SAMPLES = hcs_pkg::AVG_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  hcs_pkg::t_in_word  i_word,
    input  hcs_pkg::t_cfg      i_cfg,
    output logic               o_res_valid,
    output hcs_pkg::t_out_word o_res_word
);
    import hcs_pkg::*;

    localparam int unsigned CMP_W = SAMPLE_W + 2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CAL  = 2'd1,
        PH_MEAS = 2'd2
    } t_phase;

    t_phase r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic signed [SAMPLE_W-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic signed [SAMPLE_W-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y, n_sum_x, n_sum_y;

    logic                       sample_ok;
    logic [CNT_W-1:0]           count_inc;
    logic                       first;
    logic signed [SAMPLE_W-1:0] cal_lo_x, cal_hi_x, cal_lo_y, cal_hi_y;
    logic signed [SUM_W-1:0]    acc_x, acc_y;
    logic signed [SAMPLE_W-1:0] avg_x, avg_y;
    logic signed [CMP_W-1:0]    ay_e, lo_e, hi_e, m_e;
    logic [STEER_W-1:0]         steer;

    // Average the running sums including the current sample
    hcs_avg_div #(.AVG_SAMPLES(AVG_SAMPLES)) u_div_x (.i_sum(acc_x), .o_avg(avg_x));
    hcs_avg_div #(.AVG_SAMPLES(AVG_SAMPLES)) u_div_y (.i_sum(acc_y), .o_avg(avg_y));

    // Bounds and sums with the current sample folded in
    always_comb begin
        sample_ok = !i_word.bus_error && (i_word.status_byte != REJECT_STATUS);
        count_inc = r_count + CNT_W'(1);
        first     = (r_count == '0);
        cal_lo_x  = (first || i_word.x_sample < r_lo_x) ? i_word.x_sample : r_lo_x;
        cal_hi_x  = (first || i_word.x_sample > r_hi_x) ? i_word.x_sample : r_hi_x;
        cal_lo_y  = (first || i_word.y_sample < r_lo_y) ? i_word.y_sample : r_lo_y;
        cal_hi_y  = (first || i_word.y_sample > r_hi_y) ? i_word.y_sample : r_hi_y;
        acc_x     = r_sum_x + SUM_W'(i_word.x_sample);
        acc_y     = r_sum_y + SUM_W'(i_word.y_sample);
    end

    // Steering decision against the y bounds widened or narrowed by the margin
    always_comb begin
        ay_e = CMP_W'(avg_y);
        lo_e = CMP_W'(r_lo_y);
        hi_e = CMP_W'(r_hi_y);
        m_e  = CMP_W'($signed({1'b0, i_cfg.margin}));
        steer = STEER_STRAIGHT;
        if (i_cfg.travel_direction == DIR_WEST_EAST) begin
            if (ay_e > hi_e + m_e) begin
                steer = STEER_RIGHT;
            end else if (ay_e < lo_e - m_e) begin
                steer = STEER_LEFT;
            end
        end else begin
            if (ay_e < hi_e - m_e) begin
                steer = STEER_RIGHT;
            end else if (ay_e > lo_e + m_e) begin
                steer = STEER_LEFT;
            end
        end
    end

    // Phase sequencing and result formation
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_lo_x  = r_lo_x;
        n_hi_x  = r_hi_x;
        n_lo_y  = r_lo_y;
        n_hi_y  = r_hi_y;
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        o_res_valid = 1'b0;
        o_res_word.result_kind = KIND_CAL;
        o_res_word.steer       = STEER_STRAIGHT;
        o_res_word.avg_x       = '0;
        o_res_word.avg_y       = '0;
        o_res_word.min_x       = r_lo_x;
        o_res_word.max_x       = r_hi_x;
        o_res_word.min_y       = r_lo_y;
        o_res_word.max_y       = r_hi_y;
        if (i_fire) begin
            unique case (i_word.command)
                CMD_START_CAL: begin
                    n_phase = PH_CAL;
                    n_count = '0;
                end
                CMD_START_MEAS: begin
                    n_phase = PH_MEAS;
                    n_count = '0;
                    n_sum_x = '0;
                    n_sum_y = '0;
                end
                CMD_SAMPLE: begin
                    if (sample_ok) begin
                        unique case (r_phase)
                            PH_CAL: begin
                                n_lo_x  = cal_lo_x;
                                n_hi_x  = cal_hi_x;
                                n_lo_y  = cal_lo_y;
                                n_hi_y  = cal_hi_y;
                                n_count = count_inc;
                                if (count_inc >= CNT_W'(CAL_SAMPLES)) begin
                                    n_phase = PH_IDLE;
                                    n_count = '0;
                                    o_res_valid      = 1'b1;
                                    o_res_word.min_x = cal_lo_x;
                                    o_res_word.max_x = cal_hi_x;
                                    o_res_word.min_y = cal_lo_y;
                                    o_res_word.max_y = cal_hi_y;
                                end
                            end
                            PH_MEAS: begin
                                n_sum_x = acc_x;
                                n_sum_y = acc_y;
                                n_count = count_inc;
                                if (count_inc >= CNT_W'(AVG_SAMPLES)) begin
                                    n_phase = PH_IDLE;
                                    n_count = '0;
                                    n_sum_x = '0;
                                    n_sum_y = '0;
                                    o_res_valid            = 1'b1;
                                    o_res_word.result_kind = KIND_STEER;
                                    o_res_word.steer       = steer;
                                    o_res_word.avg_x       = avg_x;
                                    o_res_word.avg_y       = avg_y;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Hold phase, counters, bounds and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_lo_x  <= '0;
            r_hi_x  <= '0;
            r_lo_y  <= '0;
            r_hi_y  <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_lo_x  <= n_lo_x;
            r_hi_x  <= n_hi_x;
            r_lo_y  <= n_lo_y;
            r_hi_y  <= n_hi_y;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
        end
    end

endmodule

// ===== rtl/heading_calibrate_and_steer.sv =====
// Heading calibration and steering. Commands and magnetometer samples enter as one
// word per cycle on the input channel while it is not stalled; a sample with a bus
// error or a status byte of exactly 0x08 is dropped. A calibration window of
// CAL_SAMPLES good samples yields one word with the x/y bounds; a measurement window of
// AVG_SAMPLES good samples yields one word with the averages (truncated toward zero)
// and a steer code from the y average against the bounds and margin. Throughput is one
// word per cycle while the input is not stalled: each word passes through an input
// register, one pass of compare/add/reciprocal-multiply logic, and a result register,
// from which its result word is presented. The input stalls only while both registers
// are full and the output is stalled. Write margin and travel_direction only while the
// block is idle.
module heading_calibrate_and_steer #(
    parameter int unsigned CAL_SAMPLES = hcs_pkg::CAL_SAMPLES_DEF,
    parameter int unsigned AVG_SAMPLES = hcs_pkg::AVG_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hcs_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  hcs_pkg::t_in_word               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output hcs_pkg::t_out_word              o_out_data
);
    import hcs_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;

    logic       advance;
    logic       in_accept;
    logic       fire;
    logic       res_valid;
    t_out_word  res_word;

    // Advance the pipe whenever the result register is free or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.margin           <= MARGIN_RESET;
            r_cfg.travel_direction <= DIR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MARGIN:     r_cfg.margin <= i_cfg_wdata;
                REG_TRAVEL_DIR: r_cfg.travel_direction <= i_cfg_wdata[0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    // Input register: load a new word unless holding a stalled one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    hcs_core #(
        .CAL_SAMPLES(CAL_SAMPLES),
        .AVG_SAMPLES(AVG_SAMPLES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_word     (r_in),
        .i_cfg      (r_cfg),
        .o_res_valid(res_valid),
        .o_res_word (res_word)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && fire && res_valid) begin
            r_out <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sim/hcs_checker.sv =====
module hcs_checker #(
    parameter int unsigned CAL_SAMPLES = hcs_pkg::CAL_SAMPLES_DEF,
    parameter int unsigned AVG_SAMPLES = hcs_pkg::AVG_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hcs_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  hcs_pkg::t_in_word             i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  hcs_pkg::t_out_word            i_out_data,
    output int                            o_fail_count,
    output int                            o_due_count,
    output int                            o_report_count
);
    import hcs_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CAL  = 2'd1,
        PH_MEAS = 2'd2
    } t_phase;

    localparam int AVG_DIV = AVG_SAMPLES;

    // Shadow copy of the registers and of the window state
    logic [CFG_W-1:0]           margin_q;
    logic                       dir_q;
    t_phase                     phase_q;
    logic [CNT_W-1:0]           count_q;
    logic signed [SAMPLE_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
    logic signed [SUM_W-1:0]    acc_x_q, acc_y_q;

    // Result words still owed by the block, oldest first
    t_out_word due_q[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Build a result word around the bounds as they stand now
    function automatic t_out_word bounds_word(input logic kind, input logic [STEER_W-1:0] dir_steer,
                                              input int ax, input int ay);
        t_out_word rep;
        rep.result_kind = kind;
        rep.steer       = dir_steer;
        rep.avg_x       = ax[SAMPLE_W-1:0];
        rep.avg_y       = ay[SAMPLE_W-1:0];
        rep.min_x       = lo_x_q;
        rep.max_x       = hi_x_q;
        rep.min_y       = lo_y_q;
        rep.max_y       = hi_y_q;
        return rep;
    endfunction

    // Advance the shadow state by one accepted word and queue any result
    task automatic track_word(input t_in_word w);
        logic signed [SAMPLE_W-1:0] x, y;
        int                         ax, ay, m, hy, ly;
        logic [STEER_W-1:0]         dir_steer;
        x = w.x_sample;
        y = w.y_sample;
        if (w.command == CMD_START_CAL) begin
            phase_q = PH_CAL;
            count_q = '0;
        end else if (w.command == CMD_START_MEAS) begin
            phase_q = PH_MEAS;
            count_q = '0;
            acc_x_q = '0;
            acc_y_q = '0;
        end else if (w.command == CMD_SAMPLE && !w.bus_error &&
                     w.status_byte != REJECT_STATUS) begin
            if (phase_q == PH_CAL) begin
                // first good sample seeds all four bounds
                if (count_q == '0) begin
                    lo_x_q = x;
                    hi_x_q = x;
                    lo_y_q = y;
                    hi_y_q = y;
                end else begin
                    if (x < lo_x_q) lo_x_q = x;
                    if (x > hi_x_q) hi_x_q = x;
                    if (y < lo_y_q) lo_y_q = y;
                    if (y > hi_y_q) hi_y_q = y;
                end
                count_q = count_q + CNT_W'(1);
                if (count_q >= CNT_W'(CAL_SAMPLES)) begin
                    phase_q = PH_IDLE;
                    count_q = '0;
                    due_q.push_back(bounds_word(KIND_CAL, STEER_STRAIGHT, 0, 0));
                end
            end else if (phase_q == PH_MEAS) begin
                acc_x_q = acc_x_q + SUM_W'(x);
                acc_y_q = acc_y_q + SUM_W'(y);
                count_q = count_q + CNT_W'(1);
                if (count_q >= CNT_W'(AVG_SAMPLES)) begin
                    // signed division truncates toward zero
                    ax = int'(acc_x_q) / AVG_DIV;
                    ay = int'(acc_y_q) / AVG_DIV;
                    m  = int'(margin_q);
                    hy = int'(hi_y_q);
                    ly = int'(lo_y_q);
                    if (dir_q == DIR_WEST_EAST) begin
                        if (ay > hy + m) dir_steer = STEER_RIGHT;
                        else if (ay < ly - m) dir_steer = STEER_LEFT;
                        else dir_steer = STEER_STRAIGHT;
                    end else begin
                        if (ay < hy - m) dir_steer = STEER_RIGHT;
                        else if (ay > ly + m) dir_steer = STEER_LEFT;
                        else dir_steer = STEER_STRAIGHT;
                    end
                    phase_q = PH_IDLE;
                    count_q = '0;
                    acc_x_q = '0;
                    acc_y_q = '0;
                    due_q.push_back(bounds_word(KIND_STEER, dir_steer, ax, ay));
                end
            end
        end
    endtask

    // Compare one result word against the oldest one owed
    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (due_q.size() == 0) begin
            report_mismatch("result word with none expected");
        end else begin
            want = due_q.pop_front();
            compare_field("result_kind", int'(got.result_kind), int'(want.result_kind));
            compare_field("steer", int'(got.steer), int'(want.steer));
            compare_field("avg_x", int'(got.avg_x), int'(want.avg_x));
            compare_field("avg_y", int'(got.avg_y), int'(want.avg_y));
            compare_field("min_x", int'(got.min_x), int'(want.min_x));
            compare_field("max_x", int'(got.max_x), int'(want.max_x));
            compare_field("min_y", int'(got.min_y), int'(want.min_y));
            compare_field("max_y", int'(got.max_y), int'(want.max_y));
        end
        o_report_count++;
    endtask

    // Watch both channels and the register port at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            margin_q       = MARGIN_RESET;
            dir_q          = DIR_RESET;
            phase_q        = PH_IDLE;
            count_q        = '0;
            lo_x_q         = '0;
            hi_x_q         = '0;
            lo_y_q         = '0;
            hi_y_q         = '0;
            acc_x_q        = '0;
            acc_y_q        = '0;
            o_fail_count   = 0;
            o_report_count = 0;
            due_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_MARGIN) margin_q = i_cfg_wdata;
                else if (i_cfg_index == REG_TRAVEL_DIR) dir_q = i_cfg_wdata[0];
            end
            if (i_in_valid && !i_in_stall) track_word(i_in_data);
            if (i_out_valid && !i_out_stall) check_word(i_out_data);
        end
        o_due_count = due_q.size();
    end

endmodule

// ===== sim/tb_heading_calibrate_and_steer.sv =====
module tb_heading_calibrate_and_steer;
    import hcs_pkg::*;

    localparam int CAL_N         = CAL_SAMPLES_DEF;
    localparam int AVG_N         = AVG_SAMPLES_DEF;
    localparam int WORD_GOAL     = 1300;
    localparam int IDLE_PCT      = 31;
    localparam int SETTLE_CYCLES = 6;
    localparam int PLAN_LEN      = 6;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_data;

    int fail_count, due_count, report_count;
    int words_sent   = 0;
    int window_words = 0;
    int settings     = 1;
    int last_cy      = 0;
    int last_sp      = 0;
    bit calm         = 1'b0;

    heading_calibrate_and_steer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    hcs_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_data     (o_out_data),
        .o_fail_count   (fail_count),
        .o_due_count    (due_count),
        .o_report_count (report_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result channel at random unless in a calm stretch
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Hard stop for a hung run
    initial begin
        #4000000;
        $display("Timeout with %0d result words still owed", due_count);
        $display("** heading_calibrate_and_steer: FAILED **");
        $finish;
    end

    function automatic t_in_word make_word(input logic [CMD_W-1:0] cmd, input int x, input int y,
                                           input logic [STATUS_W-1:0] st, input logic be);
        t_in_word w;
        w.command     = cmd;
        w.x_sample    = x[SAMPLE_W-1:0];
        w.y_sample    = y[SAMPLE_W-1:0];
        w.status_byte = st;
        w.bus_error   = be;
        return w;
    endfunction

    function automatic int rand16();
        return int'($signed(16'($urandom)));
    endfunction

    function automatic logic [STATUS_W-1:0] good_status();
        int unsigned s;
        do s = $urandom_range(255); while (s == 32'(REJECT_STATUS));
        return s[STATUS_W-1:0];
    endfunction

    // Pick a value around a center, clamped, with the odd extreme
    function automatic int pick_near(input int center, input int spread);
        int v;
        if ($urandom_range(99) < 3) return $urandom_range(1) ? 32767 : -32768;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // Offer one word, idling first at random, and hold it until taken
    task automatic put_word(input t_in_word w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // Send a good sample, sometimes preceded by a rejected one
    task automatic feed_sample(input int x, input int y);
        logic be;
        if ($urandom_range(99) < 12) begin
            be = 1'($urandom_range(1));
            put_word(make_word(CMD_SAMPLE, rand16(), rand16(),
                               be ? STATUS_W'($urandom_range(255)) : REJECT_STATUS, be));
        end
        put_word(make_word(CMD_SAMPLE, x, y, good_status(), 1'b0));
        window_words++;
    endtask

    task automatic calibrate_window();
        int cx, sel;
        cx      = rand16();
        last_cy = rand16();
        sel     = $urandom_range(2);
        last_sp = (sel == 0) ? $urandom_range(50) : (sel == 1) ? $urandom_range(2000)
                                                               : $urandom_range(32767);
        put_word(make_word(CMD_START_CAL, rand16(), rand16(), STATUS_W'($urandom), 1'b0));
        window_words++;
        for (int i = 0; i < CAL_N; i++) begin
            feed_sample(pick_near(cx, last_sp), pick_near(last_cy, last_sp));
        end
    endtask

    // Aim the y average near the calibrated band so all steer codes show up
    task automatic measure_window();
        int reach, aim, sp;
        reach = last_sp + 600;
        aim   = last_cy + int'($urandom_range(2 * reach)) - reach;
        sp    = $urandom_range(400);
        put_word(make_word(CMD_START_MEAS, rand16(), rand16(), STATUS_W'($urandom), 1'b0));
        window_words++;
        for (int i = 0; i < AVG_N; i++) begin
            feed_sample(rand16(), pick_near(aim, sp));
        end
    endtask

    // Start a window, cut it short, and sometimes restart the other kind
    task automatic broken_window();
        bit cal;
        int len;
        cal = 1'($urandom_range(1));
        len = $urandom_range((cal ? CAL_N : AVG_N) - 1);
        put_word(make_word(cal ? CMD_START_CAL : CMD_START_MEAS, 0, 0, 8'h00, 1'b0));
        window_words++;
        for (int i = 0; i < len; i++) feed_sample(rand16(), rand16());
        if ($urandom_range(1)) begin
            put_word(make_word(cal ? CMD_START_MEAS : CMD_START_CAL, 0, 0, 8'h00, 1'b0));
            window_words++;
        end
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) begin
            put_word(make_word(CMD_W'($urandom_range(3)), rand16(), rand16(),
                               STATUS_W'($urandom_range(255)), 1'($urandom_range(1))));
        end
    endtask

    task automatic run_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            calibrate_window();
            measure_window();
        end else if (pick < 80) begin
            measure_window();
        end else if (pick < 90) begin
            broken_window();
        end else begin
            noise_burst();
        end
    endtask

    // Drop valid, wait until nothing is owed, then let the pipeline drain
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (due_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_settings(input int unsigned band, input bit dir);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MARGIN;
        i_cfg_wdata <= band[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= REG_TRAVEL_DIR;
        i_cfg_wdata <= CFG_W'(dir);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    task automatic directed_words();
        // measure against the reset bounds, with extremes and rejects mixed in
        put_word(make_word(CMD_START_MEAS, 0, 0, 8'h00, 1'b0));
        put_word(make_word(CMD_SAMPLE, 32767, 32767, 8'h00, 1'b0));
        put_word(make_word(CMD_SAMPLE, -32768, -32768, 8'hFF, 1'b0));
        put_word(make_word(CMD_SAMPLE, 1234, -5, REJECT_STATUS, 1'b0));
        put_word(make_word(CMD_SAMPLE, 32767, 32767, 8'hF7, 1'b0));
        put_word(make_word(CMD_SAMPLE, -1, -1, REJECT_STATUS, 1'b1));
        put_word(make_word(CMD_SAMPLE, 32767, 32767, 8'h09, 1'b0));
        put_word(make_word(CMD_SAMPLE, 0, 1, 8'h07, 1'b0));
        // sample while idle and the unused command
        put_word(make_word(CMD_SAMPLE, 100, 100, 8'h00, 1'b0));
        put_word(make_word(CMD_UNUSED, -1, -1, 8'hFF, 1'b1));
        // calibration restarted midway, then a full window
        put_word(make_word(CMD_START_CAL, 0, 0, 8'h00, 1'b0));
        put_word(make_word(CMD_SAMPLE, 5000, 5000, 8'h00, 1'b0));
        put_word(make_word(CMD_SAMPLE, 6000, -6000, 8'h00, 1'b0));
        put_word(make_word(CMD_START_CAL, 0, 0, 8'h00, 1'b0));
        put_word(make_word(CMD_SAMPLE, -32768, 32767, 8'h80, 1'b0));
        put_word(make_word(CMD_SAMPLE, 32767, -32768, 8'h01, 1'b0));
        put_word(make_word(CMD_SAMPLE, 0, 0, 8'h10, 1'b0));
        put_word(make_word(CMD_SAMPLE, -1, 1, 8'h00, 1'b0));
        for (int i = 0; i < CAL_N - 4; i++) begin
            put_word(make_word(CMD_SAMPLE, rand16(), rand16(), good_status(), 1'b0));
        end
    endtask

    initial begin
        int unsigned band_plan[PLAN_LEN];
        bit          dir_plan[PLAN_LEN];
        int          budget;
        band_plan = '{0, 255, 0, 255, 0, 0};
        dir_plan  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
        band_plan[4] = $urandom_range(255);
        band_plan[5] = $urandom_range(255);
        dir_plan[4]  = 1'($urandom_range(1));
        dir_plan[5]  = 1'($urandom_range(1));

        // hold reset, then run directed words with the reset settings
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_words();

        // random windows, one register setting per stretch
        for (int p = 0; p < PLAN_LEN; p++) begin
            settle();
            program_settings(band_plan[p], dir_plan[p]);
            calm   = (p == 2);
            budget = window_words + WORD_GOAL / PLAN_LEN;
            while (window_words < budget) run_sequence();
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d input words under %0d register settings;", words_sent, settings);
        $display("checked %0d calibration and steering result words.", report_count);
        if (fail_count == 0 && due_count == 0) begin
            $display("** heading_calibrate_and_steer: PASSED **");
        end else begin
            $display("** heading_calibrate_and_steer: FAILED **");
        end
        $finish;
    end

endmodule
